// ===== design/smsp_pkg.sv =====
// Shared types and constants for the straight-move speed profile.
`default_nettype none
package smsp_pkg;

	// field widths
	localparam int SpeedW     = 17;
	localparam int RightW     = 18;
	localparam int PeriodW    = 10;
	localparam int FieldCntW  = 20;
	localparam int GainW      = 16;
	localparam int DistW      = 16;
	localparam int TimeW      = 32;
	localparam int CfgIndexW  = 3;
	localparam int CfgDataW   = 20;

	localparam int CountBitsDefault = 20;

	// Q16 arithmetic constants
	localparam logic [16:0] QOne      = 17'd65536;
	localparam logic [16:0] MulUp     = 17'd75366;  // 1.15
	localparam logic [15:0] MulDown   = 16'd58982;  // 0.90
	localparam logic [17:0] DistScale = 18'd136882; // 1/64 cm to pulses, Q16
	localparam logic [15:0] RoundHalf = 16'd32768;

	// register reset values
	localparam logic [16:0] MaxSpeedRst   = 17'd26214;
	localparam logic [16:0] StartSpeedRst = 17'd9830;
	localparam logic [9:0]  AccelPerRst   = 10'd150;
	localparam logic [9:0]  TrimPerRst    = 10'd100;
	localparam logic [19:0] AccelCapRst   = 20'd3000;
	localparam logic [19:0] DecelWinRst   = 20'd2500;
	localparam logic [15:0] GainRst       = 16'd75;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ACCEL  = 2'd1,
		PH_CRUISE = 2'd2
	} phase_t;

	typedef enum logic {
		ACT_START  = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	typedef enum logic [CfgIndexW-1:0] {
		REG_MAX_SPEED   = 3'd0,
		REG_START_SPEED = 3'd1,
		REG_ACCEL_PER   = 3'd2,
		REG_TRIM_PER    = 3'd3,
		REG_ACCEL_CAP   = 3'd4,
		REG_DECEL_WIN   = 3'd5,
		REG_GAIN        = 3'd6
	} cfg_reg_t;

endpackage
`default_nettype wire

// ===== design/smsp_if.sv =====
// Channel interfaces: input items, result items and register writes.
`default_nettype none
interface smsp_in_if;
	logic                               valid;
	logic                               ready;
	logic                               action;
	logic [smsp_pkg::DistW-1:0]         distance;
	logic [smsp_pkg::TimeW-1:0]         now_ms;
	logic [smsp_pkg::FieldCntW-1:0]     count_left;
	logic [smsp_pkg::FieldCntW-1:0]     count_right;

	modport source (output valid, action, distance, now_ms, count_left, count_right,
		input ready);
	modport sink (input valid, action, distance, now_ms, count_left, count_right,
		output ready);
endinterface

interface smsp_out_if;
	logic                               valid;
	logic                               ready;
	logic [smsp_pkg::SpeedW-1:0]        left_cmd;
	logic signed [smsp_pkg::RightW-1:0] right_cmd;
	logic                               cmd_update;
	logic                               moving;
	logic                               finished;

	modport source (output valid, left_cmd, right_cmd, cmd_update, moving, finished,
		input ready);
	modport sink (input valid, left_cmd, right_cmd, cmd_update, moving, finished,
		output ready);
endinterface

interface smsp_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [smsp_pkg::CfgIndexW-1:0]     index;
	logic [smsp_pkg::CfgDataW-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/straight_move_speed_profile.sv =====
// Top level: straight-move trapezoidal speed profile for a two-wheel drive.
//
// in_ch carries start transactions (action 0, distance and now_ms) and sample
// transactions (action 1, now_ms and both encoder counts). Every input
// transaction yields exactly one result transaction on out_ch with the wheel
// commands (Q16), an update flag, the moving flag and the finish flag.
// cfg takes register writes at any time and is always ready; writes are
// meant to happen while no transaction is in flight.
//
// An accepted transaction lands in the input stage register, is evaluated
// against the profile state once the result register is free or being
// taken, and is written to the result register. One transaction per cycle
// is sustained while out_ch does not stall; the state update is a single
// combinational pass (a few multiplies plus compares) per item.
// When out_ch stalls, the result and one more transaction are held; in_ch
// ready then drops until out_ch takes the result.
// Reset clears both stages, returns the profile to idle with zero speed
// and target, and loads the register defaults.
`default_nettype none
module straight_move_speed_profile #(
	parameter int COUNT_BITS = smsp_pkg::CountBitsDefault
) (
	input  wire            clk,
	input  wire            arst_n,
	smsp_in_if.sink        in_ch,
	smsp_out_if.source     out_ch,
	smsp_cfg_if.sink       cfg
);

	localparam int CW   = COUNT_BITS;
	localparam int CMPW = 33;
	localparam int DW   = CW + 1;
	localparam int PW   = DW + 17;

	// configuration registers
	logic [16:0] max_speed_q, start_speed_q;
	logic [9:0]  accel_per_q, trim_per_q;
	logic [19:0] accel_cap_q, decel_win_q;
	logic [15:0] gain_q;

	// profile state
	smsp_pkg::phase_t phase_q;
	logic [16:0]      cur_speed_q;
	logic [31:0]      last_ms_q;
	logic [CW-1:0]    target_q;

	// input stage
	logic        valid_s1;
	logic        action_s1;
	logic [15:0] distance_s1;
	logic [31:0] now_s1;
	logic [19:0] cnt_l_s1, cnt_r_s1;

	// result stage
	logic               valid_s2;
	logic [16:0]        left_s2;
	logic signed [17:0] right_s2;
	logic               upd_s2, moving_s2, fin_s2;

	logic adv;

	// next-state logic
	smsp_pkg::phase_t   nxt_phase;
	logic [16:0]        nxt_speed;
	logic [31:0]        nxt_last;
	logic [CW-1:0]      nxt_target;
	logic [16:0]        r_left;
	logic signed [17:0] r_right;
	logic               r_upd, r_fin;

	logic [CW-1:0]         cl, cr;
	logic [31:0]           dt;
	logic [34:0]           up_prod;
	logic [16:0]           up_sat;
	logic [33:0]           down_prod;
	logic [16:0]           down_spd;
	logic [33:0]           dist_prod;
	logic [17:0]           tgt_full;
	logic [CW-1:0]         tgt_sat;
	logic [CMPW-1:0]       cl_x, tgt_x, cap_x, win_x;
	logic signed [DW-1:0]  diff;
	logic signed [16:0]    gain_s;
	logic signed [PW-1:0]  bal_prod, bal_sum, pos_lim, neg_lim;
	logic signed [17:0]    bal_right;
	logic [16:0]           trim_spd;
	logic                  in_window;

	assign adv          = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || adv;
	assign cfg.ready    = 1'b1;

	assign out_ch.valid      = valid_s2;
	assign out_ch.left_cmd   = left_s2;
	assign out_ch.right_cmd  = right_s2;
	assign out_ch.cmd_update = upd_s2;
	assign out_ch.moving     = moving_s2;
	assign out_ch.finished   = fin_s2;

	// datapath pieces
	assign cl = CW'(cnt_l_s1);
	assign cr = CW'(cnt_r_s1);
	assign dt = now_s1 - last_ms_q;

	assign up_prod = 35'(cur_speed_q) * 35'(smsp_pkg::MulUp) + 35'(smsp_pkg::RoundHalf);
	assign up_sat  = (up_prod[34:16] > 19'(smsp_pkg::QOne)) ? smsp_pkg::QOne
		: up_prod[32:16];

	assign down_prod = 34'(cur_speed_q) * 34'(smsp_pkg::MulDown)
		+ 34'(smsp_pkg::RoundHalf);
	assign down_spd  = down_prod[32:16];

	assign dist_prod = 34'(distance_s1) * 34'(smsp_pkg::DistScale);
	assign tgt_full  = dist_prod[33:16];
	// target saturates at the largest count
	assign tgt_sat   = ((36'(tgt_full) >> CW) != 36'd0) ? {CW{1'b1}} : CW'(tgt_full);

	assign cl_x  = CMPW'(cl);
	assign tgt_x = CMPW'(target_q);
	assign cap_x = CMPW'(accel_cap_q);
	assign win_x = CMPW'(decel_win_q);

	assign in_window = (tgt_x >= win_x) && (cl_x >= tgt_x - win_x);
	assign trim_spd  = in_window ? down_spd : cur_speed_q;

	// balance: arithmetic shift gives the floor of the Q16 product
	assign diff     = signed'({1'b0, cl}) - signed'({1'b0, cr});
	assign gain_s   = signed'({1'b0, gain_q});
	assign bal_prod = PW'(diff) * PW'(gain_s);
	assign bal_sum  = (bal_prod >>> 16) + PW'(signed'({1'b0, trim_spd}));
	assign pos_lim  = PW'(65536);
	assign neg_lim  = PW'(-65536);
	assign bal_right = (bal_sum > pos_lim) ? 18'sd65536
		: (bal_sum < neg_lim) ? -18'sd65536 : 18'(bal_sum);

	always_comb begin
		nxt_phase  = phase_q;
		nxt_speed  = cur_speed_q;
		nxt_last   = last_ms_q;
		nxt_target = target_q;
		r_left     = '0;
		r_right    = '0;
		r_upd      = 1'b0;
		r_fin      = 1'b0;
		if (action_s1 == smsp_pkg::ACT_START) begin
			nxt_target = tgt_sat;
			nxt_speed  = start_speed_q;
			nxt_last   = now_s1;
			nxt_phase  = smsp_pkg::PH_ACCEL;
			r_left     = start_speed_q;
			r_right    = signed'({1'b0, start_speed_q});
			r_upd      = 1'b1;
		end else begin
			case (phase_q)
				smsp_pkg::PH_ACCEL: begin
					if (dt >= 32'(accel_per_q)) begin
						nxt_speed = up_sat;
						nxt_last  = now_s1;
						r_left    = up_sat;
						r_right   = signed'({1'b0, up_sat});
						r_upd     = 1'b1;
					end
					if (!(nxt_speed < max_speed_q && cl_x < cap_x && cl_x <= tgt_x)) begin
						nxt_speed = max_speed_q;
						if (cl_x > tgt_x) begin
							nxt_phase = smsp_pkg::PH_IDLE;
							r_left    = '0;
							r_right   = '0;
							r_upd     = 1'b1;
							r_fin     = 1'b1;
						end else begin
							nxt_phase = smsp_pkg::PH_CRUISE;
						end
					end
				end
				smsp_pkg::PH_CRUISE: begin
					if (dt >= 32'(trim_per_q)) begin
						nxt_speed = trim_spd;
						nxt_last  = now_s1;
						r_left    = trim_spd;
						r_right   = bal_right;
						r_upd     = 1'b1;
					end
					// finish check comes after any trim on the same item
					if (cl_x > tgt_x) begin
						nxt_phase = smsp_pkg::PH_IDLE;
						r_left    = '0;
						r_right   = '0;
						r_upd     = 1'b1;
						r_fin     = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q   <= smsp_pkg::MaxSpeedRst;
			start_speed_q <= smsp_pkg::StartSpeedRst;
			accel_per_q   <= smsp_pkg::AccelPerRst;
			trim_per_q    <= smsp_pkg::TrimPerRst;
			accel_cap_q   <= smsp_pkg::AccelCapRst;
			decel_win_q   <= smsp_pkg::DecelWinRst;
			gain_q        <= smsp_pkg::GainRst;
		end else if (cfg.valid) begin
			case (cfg.index)
				smsp_pkg::REG_MAX_SPEED:   max_speed_q   <= cfg.data[16:0];
				smsp_pkg::REG_START_SPEED: start_speed_q <= cfg.data[16:0];
				smsp_pkg::REG_ACCEL_PER:   accel_per_q   <= cfg.data[9:0];
				smsp_pkg::REG_TRIM_PER:    trim_per_q    <= cfg.data[9:0];
				smsp_pkg::REG_ACCEL_CAP:   accel_cap_q   <= cfg.data[19:0];
				smsp_pkg::REG_DECEL_WIN:   decel_win_q   <= cfg.data[19:0];
				smsp_pkg::REG_GAIN:        gain_q        <= cfg.data[15:0];
				default: begin
				end
			endcase
		end
	end

	// profile state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= smsp_pkg::PH_IDLE;
			cur_speed_q <= '0;
			last_ms_q   <= '0;
			target_q    <= '0;
		end else if (adv) begin
			phase_q     <= nxt_phase;
			cur_speed_q <= nxt_speed;
			last_ms_q   <= nxt_last;
			target_q    <= nxt_target;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			action_s1   <= in_ch.action;
			distance_s1 <= in_ch.distance;
			now_s1      <= in_ch.now_ms;
			cnt_l_s1    <= in_ch.count_left;
			cnt_r_s1    <= in_ch.count_right;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_s2   <= r_left;
			right_s2  <= r_right;
			upd_s2    <= r_upd;
			moving_s2 <= (nxt_phase != smsp_pkg::PH_IDLE);
			fin_s2    <= r_fin;
		end
	end

endmodule
`default_nettype wire
